// ===== rtl/waveform_window_feature_extractor_assert.svh =====
// ----------------------------------------------------------------------------
// Waveform window feature extractor: assertion macros
// Concurrent check shorthands clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_WINDOW_FEATURE_EXTRACTOR_ASSERT_SVH
`define WAVEFORM_WINDOW_FEATURE_EXTRACTOR_ASSERT_SVH

// Same-cycle implication check
`define WWFE_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wwfe check failed");

// Next-cycle implication check
`define WWFE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wwfe check failed");

`endif

// ===== rtl/wwfe_pkg.sv =====
// ----------------------------------------------------------------------------
// wwfe_pkg
// Shared widths, codes and types of the waveform window feature extractor.
// ----------------------------------------------------------------------------
package wwfe_pkg;

    // Default sizing
    localparam int WW_MAX_SAMPLES = 1024;
    localparam int WW_MIN_SAMPLES = 250;

    // Field widths
    localparam int SAMPLE_W    = 14;
    localparam int CFG_W       = 10;
    localparam int SUM_W       = 24;
    localparam int ENERGY_W    = 25;
    localparam int BASE_W      = 22;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int BASE_FRAC_W = 8;

    localparam logic [SAMPLE_W-1:0] SIGN_BIT    = 14'h2000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_ONES = 14'h3FFF;
    localparam logic [BASE_W-1:0]   BASE_MAX    = 22'd4194048;

    // Shared divider sizing
    localparam int DIV_DVD_W  = SUM_W + 1 + BASE_FRAC_W;
    localparam int DIV_DVS_W  = 12;
    localparam int DIV_STEP_W = 6;
    localparam logic [DIV_STEP_W-1:0] PEAK_STEPS = 6'd14;
    localparam logic [DIV_STEP_W-1:0] BASE_STEPS = 6'd33;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_END    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THIRD_START  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THIRD_END    = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PAST   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOBASE = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0] first_start;
        logic [CFG_W-1:0] first_end;
        logic [CFG_W-1:0] second_start;
        logic [CFG_W-1:0] second_end;
        logic [CFG_W-1:0] third_start;
        logic [CFG_W-1:0] third_end;
    } cfg_t;

    typedef struct packed {
        logic                  start;
        logic [DIV_STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic sample_en;
        logic peak_en;
        logic clear;
    } acc_ctrl_t;

    typedef struct packed {
        logic active;
        logic in_a;
        logic in_b;
        logic in_c;
    } win_hit_t;

endpackage

// ===== rtl/wwfe_divider.sv =====
// ----------------------------------------------------------------------------
// wwfe_divider
// Shared restoring divider, one quotient bit per cycle. The dividend is
// loaded left-aligned so that a short division only runs its own bit count.
// ----------------------------------------------------------------------------
module wwfe_divider
    import wwfe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_req_t             req,
    input  logic [DIV_DVD_W-1:0] dividend,
    input  logic [DIV_DVS_W-1:0] divisor,
    output div_stat_t            stat,
    output logic [DIV_DVD_W-1:0] quotient
);

    logic [DIV_DVS_W-1:0]  rem_reg, rem_next;
    logic [DIV_DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DIV_DVD_W-1:0]  quo_reg, quo_next;
    logic [DIV_STEP_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_DVS_W:0]    shifted;
    logic [DIV_DVS_W:0]    trial;
    logic                  fits;

    // Shift in the next dividend bit and try the subtraction
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_DVD_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        fits      = (shifted >= {1'b0, dvs_reg});
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[DIV_DVS_W-1:0] : shifted[DIV_DVS_W-1:0];
            quo_next = {quo_reg[DIV_DVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Hold operands
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== rtl/wwfe_accum.sv =====
// ----------------------------------------------------------------------------
// wwfe_accum
// Waveform state: sample count, window sums, peak sum and extreme positions.
// ----------------------------------------------------------------------------
module wwfe_accum
    import wwfe_pkg::*;
#(
    parameter int  MAX_SAMPLES = WW_MAX_SAMPLES,
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  acc_ctrl_t           ctrl,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [SAMPLE_W-1:0] peak_quo,
    output win_hit_t            hit,
    output logic [CNT_W-1:0]    sample_count,
    output logic [SUM_W-1:0]    sum_first,
    output logic [SUM_W-1:0]    sum_second,
    output logic [SUM_W-1:0]    sum_third,
    output logic [SAMPLE_W-1:0] peak_sum,
    output logic [CFG_W-1:0]    max_position,
    output logic [CFG_W-1:0]    min_position
);

    localparam int IDX_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CNT_W-1:0]    count_reg;
    logic [SUM_W-1:0]    sum_a_reg, sum_b_reg, sum_c_reg;
    logic [SAMPLE_W-1:0] peak_reg;
    logic [SAMPLE_W-1:0] max_val_reg, min_val_reg;
    logic [CFG_W-1:0]    max_pos_reg, min_pos_reg;
    logic [IDX_W-1:0]    idx;

    function automatic logic in_win(input logic [IDX_W-1:0] i,
                                    input logic [CFG_W-1:0] lo,
                                    input logic [CFG_W-1:0] hi);
        in_win = (i >= IDX_W'(lo)) && (i <= IDX_W'(hi));
    endfunction

    // Classify the current index against the windows
    always_comb
    begin
        idx        = IDX_W'(count_reg);
        hit.active = (count_reg < CNT_W'(MAX_SAMPLES));
        hit.in_a   = in_win(idx, cfg.first_start, cfg.first_end);
        hit.in_b   = in_win(idx, cfg.second_start, cfg.second_end);
        hit.in_c   = in_win(idx, cfg.third_start, cfg.third_end);
    end

    // Fold in one sample, one peak quotient, or clear for the next waveform
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            sum_a_reg   <= '0;
            sum_b_reg   <= '0;
            sum_c_reg   <= '0;
            peak_reg    <= '0;
            max_val_reg <= '0;
            max_pos_reg <= '0;
            min_val_reg <= SAMPLE_ONES;
            min_pos_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            count_reg   <= '0;
            sum_a_reg   <= '0;
            sum_b_reg   <= '0;
            sum_c_reg   <= '0;
            peak_reg    <= '0;
            max_val_reg <= '0;
            max_pos_reg <= '0;
            min_val_reg <= SAMPLE_ONES;
            min_pos_reg <= '0;
        end
        else
        begin
            if (ctrl.sample_en && hit.active)
            begin
                if (hit.in_a)
                begin
                    sum_a_reg <= sum_a_reg + SUM_W'(sample);
                end
                if (hit.in_b)
                begin
                    sum_b_reg <= sum_b_reg + SUM_W'(sample);
                end
                if (hit.in_c)
                begin
                    sum_c_reg <= sum_c_reg + SUM_W'(sample);
                end
                if (sample > max_val_reg)
                begin
                    max_val_reg <= sample;
                    max_pos_reg <= idx[CFG_W-1:0];
                end
                if (sample <= min_val_reg)
                begin
                    min_val_reg <= sample;
                    min_pos_reg <= idx[CFG_W-1:0];
                end
                count_reg <= count_reg + 1'b1;
            end
            if (ctrl.peak_en)
            begin
                peak_reg <= peak_reg + peak_quo;
            end
        end
    end

    assign sample_count = count_reg;
    assign sum_first    = sum_a_reg;
    assign sum_second   = sum_b_reg;
    assign sum_third    = sum_c_reg;
    assign peak_sum     = peak_reg;
    assign max_position = max_pos_reg;
    assign min_position = min_pos_reg;

endmodule

// ===== rtl/waveform_window_feature_extractor.sv =====
// ----------------------------------------------------------------------------
// waveform_window_feature_extractor
// Window energy, peak, baseline and extreme positions of one waveform.
// ----------------------------------------------------------------------------
// Samples stream in one item at a time, the final one flagged by last_sample;
// in_stall is high while an item is being worked on. A sample outside window
// A needs no divider. For a sample inside window A, its quotient by the
// window length comes from the shared one-bit-per-cycle divider in 14 steps.
// After the last sample the sequencer runs the sum, difference and energy
// states, then, when the status is OK, 33 divider steps for the baseline,
// and then loads the output register once it is free. The peak and the
// baseline share the one divider. A finished result waits in its own
// register, so the next waveform may start while it is not yet taken.
// ----------------------------------------------------------------------------
`include "waveform_window_feature_extractor_assert.svh"

module waveform_window_feature_extractor
    import wwfe_pkg::*;
#(
    parameter int MAX_SAMPLES = WW_MAX_SAMPLES,
    parameter int MIN_SAMPLES = WW_MIN_SAMPLES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [SAMPLE_W-1:0]  raw_sample,
    input  logic                 last_sample,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ENERGY_W-1:0]  energy,
    output logic [SAMPLE_W-1:0]  peak,
    output logic [BASE_W-1:0]    baseline,
    output logic [CFG_W-1:0]     max_index,
    output logic [CFG_W-1:0]     min_index,
    output logic [STATUS_W-1:0]  status
);

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int MIN_W  = $clog2(MIN_SAMPLES + 1);
    localparam int CMP_A  = (CNT_W > MIN_W) ? CNT_W : MIN_W;
    localparam int CMP_W  = (CMP_A > CFG_W) ? CMP_A : CFG_W;
    localparam int NB_W   = DIV_DVS_W + 1;
    localparam int AB_W   = SUM_W + 1;
    localparam int DIFF_W = SUM_W + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PEAK,
        S_FIN_SUM,
        S_FIN_DIFF,
        S_FIN_ENERGY,
        S_BASE,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    cfg_t                  cfg_reg;
    logic                  last_reg, last_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [AB_W-1:0]       ab_reg, ab_next;
    logic [DIFF_W-1:0]     diff_reg, diff_next;
    logic [ENERGY_W-1:0]   energy_reg, energy_next;
    logic [SAMPLE_W-1:0]   peak_reg, peak_next;
    logic [BASE_W-1:0]     base_reg, base_next;
    logic                  out_valid_reg, out_valid_next;
    logic [ENERGY_W-1:0]   out_energy_reg, out_energy_next;
    logic [SAMPLE_W-1:0]   out_peak_reg, out_peak_next;
    logic [BASE_W-1:0]     out_base_reg, out_base_next;
    logic [CFG_W-1:0]      out_max_reg, out_max_next;
    logic [CFG_W-1:0]      out_min_reg, out_min_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;

    logic [SAMPLE_W-1:0]   sample;
    logic [DIV_DVS_W-1:0]  len_a;
    logic [NB_W-1:0]       nbase;
    logic                  nbase_pos;
    logic                  past_any;
    logic [DIFF_W-1:0]     diff_neg;
    logic                  failed;

    acc_ctrl_t             acc_ctrl;
    win_hit_t              hit;
    logic [CNT_W-1:0]      sample_count;
    logic [SUM_W-1:0]      sum_first, sum_second, sum_third;
    logic [SAMPLE_W-1:0]   peak_sum;
    logic [CFG_W-1:0]      max_position, min_position;

    div_req_t              div_req;
    div_stat_t             div_stat;
    logic [DIV_DVD_W-1:0]  div_dividend;
    logic [DIV_DVS_W-1:0]  div_divisor;
    logic [DIV_DVD_W-1:0]  div_quotient;

    function automatic logic past_end(input logic [CFG_W-1:0] lo,
                                      input logic [CFG_W-1:0] hi,
                                      input logic [CMP_W-1:0] cnt);
        past_end = (lo <= hi) && (CMP_W'(hi) >= cnt);
    endfunction

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIRST_START:  cfg_reg.first_start  <= cfg_data;
                CFG_FIRST_END:    cfg_reg.first_end    <= cfg_data;
                CFG_SECOND_START: cfg_reg.second_start <= cfg_data;
                CFG_SECOND_END:   cfg_reg.second_end   <= cfg_data;
                CFG_THIRD_START:  cfg_reg.third_start  <= cfg_data;
                CFG_THIRD_END:    cfg_reg.third_end    <= cfg_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Offset the sample and derive window lengths
    always_comb
    begin
        sample    = raw_sample ^ SIGN_BIT;
        len_a     = DIV_DVS_W'(cfg_reg.first_end) - DIV_DVS_W'(cfg_reg.first_start)
                  + DIV_DVS_W'(1);
        nbase     = NB_W'(cfg_reg.first_end) - NB_W'(cfg_reg.first_start)
                  + NB_W'(cfg_reg.second_end) - NB_W'(cfg_reg.second_start)
                  + NB_W'(2);
        nbase_pos = !nbase[NB_W-1] && (nbase != '0);
        past_any  = past_end(cfg_reg.first_start, cfg_reg.first_end, CMP_W'(sample_count))
                 || past_end(cfg_reg.second_start, cfg_reg.second_end, CMP_W'(sample_count))
                 || past_end(cfg_reg.third_start, cfg_reg.third_end, CMP_W'(sample_count));
        diff_neg  = -diff_reg;
        failed    = (status_reg == ST_SHORT) || (status_reg == ST_PAST);
    end

    // Feed the divider with the peak or the baseline operands
    assign div_dividend = (state_reg == S_IDLE)
                        ? {sample, {(DIV_DVD_W - SAMPLE_W){1'b0}}}
                        : {ab_reg, {BASE_FRAC_W{1'b0}}};
    assign div_divisor  = (state_reg == S_IDLE) ? len_a : nbase[DIV_DVS_W-1:0];

    // Sequence one item through the accumulator and the divider
    always_comb
    begin
        state_next      = state_reg;
        last_next       = last_reg;
        status_next     = status_reg;
        ab_next         = ab_reg;
        diff_next       = diff_reg;
        energy_next     = energy_reg;
        peak_next       = peak_reg;
        base_next       = base_reg;
        out_valid_next  = out_valid_reg;
        out_energy_next = out_energy_reg;
        out_peak_next   = out_peak_reg;
        out_base_next   = out_base_reg;
        out_max_next    = out_max_reg;
        out_min_next    = out_min_reg;
        out_status_next = out_status_reg;
        acc_ctrl        = '0;
        div_req         = '0;

        // Drop the result once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    acc_ctrl.sample_en = 1'b1;
                    last_next          = last_sample;
                    if (hit.active && hit.in_a)
                    begin
                        div_req.start = 1'b1;
                        div_req.steps = PEAK_STEPS;
                        state_next    = S_PEAK;
                    end
                    else if (last_sample)
                    begin
                        state_next = S_FIN_SUM;
                    end
                end
            end
            S_PEAK:
            begin
                if (div_stat.done)
                begin
                    acc_ctrl.peak_en = 1'b1;
                    state_next       = last_reg ? S_FIN_SUM : S_IDLE;
                end
            end
            S_FIN_SUM:
            begin
                ab_next = AB_W'(sum_first) + AB_W'(sum_second);
                priority if (CMP_W'(sample_count) < CMP_W'(MIN_SAMPLES))
                begin
                    status_next = ST_SHORT;
                end
                else if (past_any)
                begin
                    status_next = ST_PAST;
                end
                else if (!nbase_pos)
                begin
                    status_next = ST_NOBASE;
                end
                else
                begin
                    status_next = ST_OK;
                end
                state_next = S_FIN_DIFF;
            end
            S_FIN_DIFF:
            begin
                diff_next  = DIFF_W'(sum_third) - DIFF_W'(ab_reg);
                state_next = S_FIN_ENERGY;
            end
            S_FIN_ENERGY:
            begin
                if (failed)
                begin
                    energy_next = '0;
                    peak_next   = '0;
                end
                else
                begin
                    energy_next = diff_reg[DIFF_W-1] ? ENERGY_W'(diff_neg)
                                                     : ENERGY_W'(diff_reg);
                    peak_next   = peak_sum;
                end
                if (status_reg == ST_OK)
                begin
                    div_req.start = 1'b1;
                    div_req.steps = BASE_STEPS;
                    state_next    = S_BASE;
                end
                else
                begin
                    base_next  = '0;
                    state_next = S_DONE;
                end
            end
            S_BASE:
            begin
                if (div_stat.done)
                begin
                    base_next  = (div_quotient > DIV_DVD_W'(BASE_MAX))
                               ? BASE_MAX : div_quotient[BASE_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Load the result once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_energy_next = energy_reg;
                    out_peak_next   = peak_reg;
                    out_base_next   = base_reg;
                    out_max_next    = max_position;
                    out_min_next    = min_position;
                    out_status_next = status_reg;
                    acc_ctrl.clear  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold sequencer state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            last_reg       <= 1'b0;
            status_reg     <= ST_OK;
            ab_reg         <= '0;
            diff_reg       <= '0;
            energy_reg     <= '0;
            peak_reg       <= '0;
            base_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_energy_reg <= '0;
            out_peak_reg   <= '0;
            out_base_reg   <= '0;
            out_max_reg    <= '0;
            out_min_reg    <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            last_reg       <= last_next;
            status_reg     <= status_next;
            ab_reg         <= ab_next;
            diff_reg       <= diff_next;
            energy_reg     <= energy_next;
            peak_reg       <= peak_next;
            base_reg       <= base_next;
            out_valid_reg  <= out_valid_next;
            out_energy_reg <= out_energy_next;
            out_peak_reg   <= out_peak_next;
            out_base_reg   <= out_base_next;
            out_max_reg    <= out_max_next;
            out_min_reg    <= out_min_next;
            out_status_reg <= out_status_next;
        end
    end

    wwfe_accum #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .ctrl         (acc_ctrl),
        .sample       (sample),
        .peak_quo     (div_quotient[SAMPLE_W-1:0]),
        .hit          (hit),
        .sample_count (sample_count),
        .sum_first    (sum_first),
        .sum_second   (sum_second),
        .sum_third    (sum_third),
        .peak_sum     (peak_sum),
        .max_position (max_position),
        .min_position (min_position)
    );

    wwfe_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign energy    = out_energy_reg;
    assign peak      = out_peak_reg;
    assign baseline  = out_base_reg;
    assign max_index = out_max_reg;
    assign min_index = out_min_reg;
    assign status    = out_status_reg;

    // Checks
    `WWFE_ASSERT_IMP(a_div_start_idle, div_req.start, !div_stat.busy)
    `WWFE_ASSERT_IMP(a_fail_zero, out_valid && (status == ST_SHORT || status == ST_PAST), energy == '0 && peak == '0 && baseline == '0)
    `WWFE_ASSERT_IMP(a_base_sat, out_valid, baseline <= BASE_MAX)

endmodule

// ===== test/waveform_window_feature_extractor_test.sv =====
// ----------------------------------------------------------------------------
// waveform_window_feature_extractor_test
// Self-checking bench for the waveform window feature extractor. A directed
// table of waveforms covers reset windows, full-scale and zero samples, short
// events, windows past the end, empty and negative windows, baseline
// saturation and waveforms longer than the capture depth. Random phases with
// fresh windows follow. Every result is compared field by field against the
// typed expectation of its row or else a behavioral model of the window sums,
// the peak, the baseline, the extreme positions and the status.
// ----------------------------------------------------------------------------
module waveform_window_feature_extractor_test;
    import wwfe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CLK_PERIOD_NS  = 12;
    localparam int     RESET_CYCLES   = 12;
    localparam int     SETTLE_CYCLES  = 50;
    localparam int     DRAIN_LIMIT    = 10000;
    localparam int     SQUEEZE_CYCLES = 1500;
    localparam int     MAX_REPORTS    = 10;
    localparam longint LIMIT_CYCLES   = 3000000;

    // Indexes past the last window register; writes there change nothing
    localparam logic [CFG_IDX_W-1:0] SPARE_REG_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] SPARE_REG_HI = 3'd7;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [SAMPLE_W-1:0] peak;
        logic [BASE_W-1:0]   baseline;
        logic [CFG_W-1:0]    max_index;
        logic [CFG_W-1:0]    min_index;
        logic [STATUS_W-1:0] status;
    } feature_t;

    typedef enum {FILL_CONST, FILL_TOGGLE, FILL_RAMP, FILL_RANDOM} fill_e;

    typedef struct {
        cfg_t                win;
        int unsigned         len;
        fill_e               fill;
        logic [SAMPLE_W-1:0] level;
        bit                  typed;
        feature_t            want;
    } wave_row_t;

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [SAMPLE_W-1:0]  raw_sample  = '0;
    logic                 last_sample = 1'b0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic [ENERGY_W-1:0]  energy;
    logic [SAMPLE_W-1:0]  peak;
    logic [BASE_W-1:0]    baseline;
    logic [CFG_W-1:0]     max_index;
    logic [CFG_W-1:0]     min_index;
    logic [STATUS_W-1:0]  status;

    // Model copy of the window registers and the waveform accumulators
    cfg_t                windows   = '0;
    int                  wave_count = 0;
    logic [SUM_W-1:0]    sum_a     = '0;
    logic [SUM_W-1:0]    sum_b     = '0;
    logic [SUM_W-1:0]    sum_c     = '0;
    logic [SAMPLE_W-1:0] peak_acc  = '0;
    logic [SAMPLE_W-1:0] top_val   = '0;
    logic [CFG_W-1:0]    top_pos   = '0;
    logic [SAMPLE_W-1:0] bot_val   = SAMPLE_ONES;
    logic [CFG_W-1:0]    bot_pos   = '0;

    feature_t    expected_features[$];
    bit          use_typed   = 1'b0;
    feature_t    typed_want  = '0;
    bit          feeder_gaps = 1'b0;
    bit          taker_gaps  = 1'b0;
    bit          squeeze_req = 1'b0;
    int          mismatches  = 0;
    int unsigned items_sent  = 0;

    waveform_window_feature_extractor u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .raw_sample (raw_sample),
        .last_sample(last_sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .energy     (energy),
        .peak       (peak),
        .baseline   (baseline),
        .max_index  (max_index),
        .min_index  (min_index),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD_NS / 2) clk = ~clk;
    end

    initial
    begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD_NS);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void flag(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function automatic cfg_t win_set(input int fs, input int fe, input int ss,
                                     input int se, input int ts, input int te);
        cfg_t w;
        w.first_start  = CFG_W'(fs);
        w.first_end    = CFG_W'(fe);
        w.second_start = CFG_W'(ss);
        w.second_end   = CFG_W'(se);
        w.third_start  = CFG_W'(ts);
        w.third_end    = CFG_W'(te);
        return w;
    endfunction

    function automatic feature_t features(input int e, input int p, input int b,
                                          input int mx, input int mn,
                                          input logic [STATUS_W-1:0] st);
        feature_t f;
        f.energy    = ENERGY_W'(e);
        f.peak      = SAMPLE_W'(p);
        f.baseline  = BASE_W'(b);
        f.max_index = CFG_W'(mx);
        f.min_index = CFG_W'(mn);
        f.status    = st;
        return f;
    endfunction

    // A non-empty window whose end the waveform never reached
    function automatic bit ends_beyond(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
        return lo <= hi && int'(hi) >= wave_count;
    endfunction

    // Fold one accepted sample into the waveform; on the last one build the result
    function automatic bit absorb_sample(input logic [SAMPLE_W-1:0] raw, input logic fin,
                                         output feature_t f);
        logic [SAMPLE_W-1:0] s;
        int                  idx;
        int                  len_a;
        int                  nbase;
        longint              diff;
        longint              base;
        f = '0;
        s = raw ^ SIGN_BIT;
        // Samples past the capture depth are neither summed nor ranked
        if (wave_count < WW_MAX_SAMPLES)
        begin
            idx = wave_count;
            if (idx >= int'(windows.first_start) && idx <= int'(windows.first_end))
            begin
                len_a    = int'(windows.first_end) - int'(windows.first_start) + 1;
                sum_a    = sum_a + SUM_W'(s);
                peak_acc = peak_acc + SAMPLE_W'(int'(s) / len_a);
            end
            if (idx >= int'(windows.second_start) && idx <= int'(windows.second_end))
                sum_b = sum_b + SUM_W'(s);
            if (idx >= int'(windows.third_start) && idx <= int'(windows.third_end))
                sum_c = sum_c + SUM_W'(s);
            if (s > top_val)
            begin
                top_val = s;
                top_pos = CFG_W'(idx);
            end
            if (s <= bot_val)
            begin
                bot_val = s;
                bot_pos = CFG_W'(idx);
            end
            wave_count++;
        end
        if (!fin)
            return 1'b0;

        nbase = (int'(windows.first_end) - int'(windows.first_start) + 1)
              + (int'(windows.second_end) - int'(windows.second_start) + 1);
        f.status = ST_OK;
        if (wave_count < WW_MIN_SAMPLES)
            f.status = ST_SHORT;
        else if (ends_beyond(windows.first_start, windows.first_end) ||
                 ends_beyond(windows.second_start, windows.second_end) ||
                 ends_beyond(windows.third_start, windows.third_end))
            f.status = ST_PAST;
        else
        begin
            diff = longint'(sum_c) - longint'(sum_a) - longint'(sum_b);
            if (diff < 0)
                diff = -diff;
            f.energy = ENERGY_W'(diff);
            f.peak   = peak_acc;
            if (nbase <= 0)
                f.status = ST_NOBASE;
            else
            begin
                base = ((longint'(sum_a) + longint'(sum_b)) << BASE_FRAC_W) / nbase;
                f.baseline = (base > longint'(BASE_MAX)) ? BASE_MAX : BASE_W'(base);
            end
        end
        f.max_index = top_pos;
        f.min_index = bot_pos;

        // Clear for the next waveform
        wave_count = 0;
        sum_a      = '0;
        sum_b      = '0;
        sum_c      = '0;
        peak_acc   = '0;
        top_val    = '0;
        top_pos    = '0;
        bot_val    = SAMPLE_ONES;
        bot_pos    = '0;
        return 1'b1;
    endfunction

    function automatic logic [SAMPLE_W-1:0] sample_at(input fill_e fill,
                                                      input logic [SAMPLE_W-1:0] level,
                                                      input int i);
        case (fill)
            FILL_CONST:  return level;
            FILL_TOGGLE: return i[0] ? ~level : level;
            FILL_RAMP:   return level + SAMPLE_W'(i * 37);
            default:     return SAMPLE_W'($urandom_range(0, 16383));
        endcase
    endfunction

    // Predict on every accepted item
    always @(posedge clk)
    begin : sample_tap
        feature_t f;
        if (rst_n && in_valid === 1'b1 && in_stall === 1'b0)
        begin
            if (absorb_sample(raw_sample, last_sample, f))
                expected_features.push_back(use_typed ? typed_want : f);
        end
    end

    // Check every accepted result against the oldest expectation
    always @(posedge clk)
    begin : result_tap
        feature_t got;
        feature_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got = '{energy, peak, baseline, max_index, min_index, status};
            if (expected_features.size() == 0)
                flag($sformatf("unexpected result %p", got));
            else
            begin
                want = expected_features.pop_front();
                if (got.energy !== want.energy)
                    flag($sformatf("energy expected %0d got %0d", want.energy, got.energy));
                if (got.peak !== want.peak)
                    flag($sformatf("peak expected %0d got %0d", want.peak, got.peak));
                if (got.baseline !== want.baseline)
                    flag($sformatf("baseline expected %0d got %0d",
                                   want.baseline, got.baseline));
                if (got.max_index !== want.max_index)
                    flag($sformatf("max_index expected %0d got %0d",
                                   want.max_index, got.max_index));
                if (got.min_index !== want.min_index)
                    flag($sformatf("min_index expected %0d got %0d",
                                   want.min_index, got.min_index));
                if (got.status !== want.status)
                    flag($sformatf("status expected %0d got %0d", want.status, got.status));
            end
        end
    end

    // Stall the result side per item; hold off for a long stretch on request
    initial
    begin : result_taker
        int hold;
        forever
        begin
            if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                hold = SQUEEZE_CYCLES;
            end
            else
                hold = taker_gaps ? $urandom_range(0, 5) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
        end
    end

    // Offer one item after a random gap and hold it until taken
    task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic fin);
        int gap;
        gap = feeder_gaps ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        raw_sample  <= s;
        last_sample <= fin;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        items_sent++;
    endtask

    task automatic send_wave(input int unsigned len, input fill_e fill,
                             input logic [SAMPLE_W-1:0] level);
        for (int i = 0; i < int'(len); i++)
            push_sample(sample_at(fill, level, i), i == int'(len) - 1);
    endtask

    // Drop valid, wait for every pending result, then let the block go quiet
    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_features.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_features.size() != 0)
        begin
            flag($sformatf("%0d results never arrived", expected_features.size()));
            expected_features.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_FIRST_START:  windows.first_start  = data;
            CFG_FIRST_END:    windows.first_end    = data;
            CFG_SECOND_START: windows.second_start = data;
            CFG_SECOND_END:   windows.second_end   = data;
            CFG_THIRD_START:  windows.third_start  = data;
            CFG_THIRD_END:    windows.third_end    = data;
            default: ;
        endcase
    endtask

    task automatic load_windows(input cfg_t w);
        write_reg(CFG_FIRST_START, w.first_start);
        write_reg(CFG_FIRST_END, w.first_end);
        write_reg(CFG_SECOND_START, w.second_start);
        write_reg(CFG_SECOND_END, w.second_end);
        write_reg(CFG_THIRD_START, w.third_start);
        write_reg(CFG_THIRD_END, w.third_end);
    endtask

    initial
    begin : stimulus
        wave_row_t   plan[$];
        cfg_t        w;
        int unsigned len;
        int unsigned pick;
        int unsigned random_items;
        int unsigned random_waves;
        int          phase;
        fill_e       fill;

        // Directed waveforms; typed rows are plain enough to read by eye
        plan.push_back('{win_set(0, 0, 0, 0, 0, 0), 1, FILL_CONST, 14'h0000, 1'b1,
                         features(0, 0, 0, 0, 0, ST_SHORT)});
        plan.push_back('{win_set(0, 0, 0, 0, 0, 0), 250, FILL_CONST, 14'h1FFF, 1'b1,
                         features(16383, 16383, 4194048, 0, 249, ST_OK)});
        plan.push_back('{win_set(0, 0, 0, 0, 0, 0), 250, FILL_CONST, 14'h2000, 1'b1,
                         features(0, 0, 0, 0, 249, ST_OK)});
        plan.push_back('{win_set(0, 9, 10, 19, 100, 149), 249, FILL_CONST, 14'h1FFF, 1'b1,
                         features(0, 0, 0, 0, 248, ST_SHORT)});
        plan.push_back('{win_set(0, 0, 0, 0, 100, 1023), 300, FILL_CONST, 14'h2000, 1'b1,
                         features(0, 0, 0, 0, 299, ST_PAST)});
        plan.push_back('{win_set(10, 5, 20, 18, 0, 249), 260, FILL_RANDOM, 14'h0000, 1'b0,
                         '0});
        plan.push_back('{win_set(5, 4, 5, 4, 3, 200), 250, FILL_TOGGLE, 14'h1FFF, 1'b0, '0});
        plan.push_back('{win_set(0, 199, 100, 50, 0, 0), 250, FILL_CONST, 14'h1FFF, 1'b0,
                         '0});
        plan.push_back('{win_set(0, 199, 100, 50, 0, 0), 255, FILL_RANDOM, 14'h0000, 1'b0,
                         '0});
        plan.push_back('{win_set(1023, 1023, 0, 1023, 0, 1023), 1024, FILL_RAMP, 14'h0000,
                         1'b0, '0});
        plan.push_back('{win_set(1000, 1023, 0, 15, 500, 1023), 1100, FILL_RANDOM, 14'h0000,
                         1'b0, '0});
        plan.push_back('{win_set(0, 1023, 512, 511, 1023, 1023), 1024, FILL_TOGGLE, 14'h0000,
                         1'b0, '0});
        plan.push_back('{win_set(3, 17, 40, 249, 0, 249), 250, FILL_TOGGLE, 14'h1FFF, 1'b0,
                         '0});
        plan.push_back('{win_set(0, 249, 0, 0, 249, 249), 300, FILL_RAMP, 14'h3FF0, 1'b0,
                         '0});

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (plan[r])
        begin
            settle();
            // Writes to the spare indexes must leave the windows alone
            if (r == 1)
            begin
                write_reg(SPARE_REG_LO, CFG_W'($urandom));
                write_reg(SPARE_REG_HI, CFG_W'($urandom));
            end
            if (plan[r].win != windows)
                load_windows(plan[r].win);
            use_typed   = plan[r].typed;
            typed_want  = plan[r].want;
            feeder_gaps = (r % 2 == 0);
            taker_gaps  = (r % 3 != 0);
            send_wave(plan[r].len, plan[r].fill, plan[r].level);
        end
        settle();
        use_typed = 1'b0;

        // Random phases: new windows, then a handful of waveforms each
        random_items = 0;
        random_waves = 0;
        phase = 0;
        while (random_items < 950 || random_waves < 40)
        begin
            phase++;
            settle();
            pick = $urandom_range(0, 9);
            w.first_start  = CFG_W'($urandom_range(0, 200));
            w.first_end    = CFG_W'($urandom_range(w.first_start, w.first_start + 49));
            w.second_start = CFG_W'($urandom_range(0, 240));
            w.second_end   = CFG_W'($urandom_range(w.second_start, 249));
            w.third_start  = CFG_W'($urandom_range(0, 240));
            w.third_end    = CFG_W'($urandom_range(w.third_start, 249));
            case (pick)
                6:
                begin
                    // Empty window B
                    w.second_start = CFG_W'($urandom_range(1, 249));
                    w.second_end   = CFG_W'($urandom_range(0, w.second_start - 1));
                end
                7:
                    w = win_set($urandom_range(0, 1023), $urandom_range(0, 1023),
                                $urandom_range(0, 1023), $urandom_range(0, 1023),
                                $urandom_range(0, 1023), $urandom_range(0, 1023));
                8:
                    w = win_set($urandom_range(0, 1) * 1023, $urandom_range(0, 1) * 1023,
                                $urandom_range(0, 1) * 1023, $urandom_range(0, 1) * 1023,
                                $urandom_range(0, 1) * 1023, $urandom_range(0, 1) * 1023);
                9:
                begin
                    // Negative B length shrinks the base count below the summed samples
                    w.first_start  = CFG_W'($urandom_range(0, 20));
                    w.first_end    = CFG_W'($urandom_range(150, 249));
                    w.second_start = CFG_W'($urandom_range(100, 249));
                    w.second_end   = CFG_W'($urandom_range(0, w.second_start - 1));
                end
                default: ;
            endcase
            load_windows(w);
            feeder_gaps = ($urandom_range(0, 3) != 0);
            taker_gaps  = ($urandom_range(0, 3) != 0);

            // Hold the result side off while short waveforms keep coming
            if (phase == 2)
            begin
                squeeze_req = 1'b1;
                repeat (10)
                begin
                    len = $urandom_range(2, 12);
                    send_wave(len, FILL_RANDOM, '0);
                    random_items += len;
                end
            end

            repeat (4)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 2)
                    len = $urandom_range(1, 249);
                else if (pick == 2)
                    len = $urandom_range(1024, 1100);
                else if (pick == 3)
                    len = 250;
                else
                    len = $urandom_range(251, 330);
                pick = $urandom_range(0, 9);
                fill = (pick == 0) ? FILL_CONST :
                       (pick == 1) ? FILL_TOGGLE :
                       (pick == 2) ? FILL_RAMP : FILL_RANDOM;
                send_wave(len, fill, SAMPLE_W'($urandom_range(0, 16383)));
                random_items += len;
                random_waves++;
            end
        end
        settle();

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== waveform_window_feature_extractor.f =====
+incdir+rtl
rtl/wwfe_pkg.sv
rtl/wwfe_divider.sv
rtl/wwfe_accum.sv
rtl/waveform_window_feature_extractor.sv
test/waveform_window_feature_extractor_test.sv
